// ===== sv/dscs_pkg.sv =====
package dscs_pkg;

    // Widths of the payload and configuration fields.
    localparam int LIMIT_W   = 16;
    localparam int PULSE_W   = 15;
    localparam int MODE_W    = 3;
    localparam int DIR_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int NUM_PINS  = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_REVERSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FORWARD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_NEUTRAL  = 2'd3;

    // Register values after reset.
    localparam logic [LIMIT_W-1:0] RST_DEBOUNCE_LIMIT = 16'd5000;
    localparam logic [PULSE_W-1:0] RST_PULSE_REVERSE  = 15'd1000;
    localparam logic [PULSE_W-1:0] RST_PULSE_FORWARD  = 15'd2000;
    localparam logic [PULSE_W-1:0] RST_PULSE_NEUTRAL  = 15'd1500;

    // Lane order of the three pins.
    localparam int LANE_ARM = 0;
    localparam int LANE_DIS = 1;
    localparam int LANE_CAM = 2;

    // Sequencer modes, one-hot.
    typedef enum logic [7:0] {
        MODE_IDLE             = 8'b0000_0001,
        MODE_COCKING          = 8'b0000_0010,
        MODE_COCKED           = 8'b0000_0100,
        MODE_FIRING           = 8'b0000_1000,
        MODE_DECOCKING        = 8'b0001_0000,
        MODE_RESETTING        = 8'b0010_0000,
        MODE_IDLE_AFTER_RESET = 8'b0100_0000,
        MODE_RECOCKING        = 8'b1000_0000
    } t_mode;

    // Mode codes as seen on the output word.
    localparam logic [MODE_W-1:0] CODE_IDLE             = 3'd0;
    localparam logic [MODE_W-1:0] CODE_COCKING          = 3'd1;
    localparam logic [MODE_W-1:0] CODE_COCKED           = 3'd2;
    localparam logic [MODE_W-1:0] CODE_FIRING           = 3'd3;
    localparam logic [MODE_W-1:0] CODE_DECOCKING        = 3'd4;
    localparam logic [MODE_W-1:0] CODE_RESETTING        = 3'd5;
    localparam logic [MODE_W-1:0] CODE_IDLE_AFTER_RESET = 3'd6;
    localparam logic [MODE_W-1:0] CODE_RECOCKING        = 3'd7;

    // Servo drive direction.
    typedef enum logic [DIR_W-1:0] {
        DIR_NEUTRAL = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2
    } t_dir;

    // Debounced pin levels handed from the lanes to the sequencer.
    typedef struct packed {
        logic arm;
        logic dis;
        logic cam;
    } t_levels;

    // Sequencer decision for one tick.
    typedef struct packed {
        t_mode mode;
        t_dir  dir;
    } t_decision;

    // One result word.
    typedef struct packed {
        logic [PULSE_W-1:0] servo_pulse;
        logic               led_on;
        logic [MODE_W-1:0]  mode_code;
        t_dir               drive_dir;
    } t_result;

    function automatic logic [MODE_W-1:0] mode_to_code(input t_mode mode);
        logic [MODE_W-1:0] code;
        case (mode)
            MODE_IDLE:             code = CODE_IDLE;
            MODE_COCKING:          code = CODE_COCKING;
            MODE_COCKED:           code = CODE_COCKED;
            MODE_FIRING:           code = CODE_FIRING;
            MODE_DECOCKING:        code = CODE_DECOCKING;
            MODE_RESETTING:        code = CODE_RESETTING;
            MODE_IDLE_AFTER_RESET: code = CODE_IDLE_AFTER_RESET;
            MODE_RECOCKING:        code = CODE_RECOCKING;
            default:               code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/dscs_in_if.sv =====
interface dscs_in_if;
    logic valid;
    logic ready;
    logic trigger_pin;
    logic disarm_pin;
    logic cam_pin;

    modport source (output valid, output trigger_pin, output disarm_pin, output cam_pin,
                    input ready);
    modport sink (input valid, input trigger_pin, input disarm_pin, input cam_pin,
                  output ready);
endinterface

// ===== sv/dscs_out_if.sv =====
interface dscs_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] servo_pulse;
    logic        led_on;
    logic [2:0]  mode_code;
    logic [1:0]  drive_dir;

    modport source (output valid, output servo_pulse, output led_on, output mode_code,
                    output drive_dir, input ready);
    modport sink (input valid, input servo_pulse, input led_on, input mode_code,
                  input drive_dir, output ready);
endinterface

// ===== sv/dscs_cfg_if.sv =====
interface dscs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/dscs_debounce.sv =====
module dscs_debounce
    import dscs_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_enable,
    input  logic               i_level,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_stable
);

    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    logic                  r_last;
    logic                  r_stable;
    logic [COUNT_BITS-1:0] r_count;
    logic                  n_last;
    logic                  n_stable;
    logic [COUNT_BITS-1:0] n_count;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      limit_ext;

    // A level change restarts the quiet count; otherwise it counts up and saturates.
    always_comb begin
        n_last  = r_last;
        n_count = r_count;
        if (i_level != r_last) begin
            n_last  = i_level;
            n_count = '0;
        end else if (r_count != {COUNT_BITS{1'b1}}) begin
            n_count = r_count + 1'b1;
        end
    end

    // The stable level follows once the last level has been quiet long enough.
    always_comb begin
        count_ext = CMP_W'(n_count);
        limit_ext = CMP_W'(i_limit);
        n_stable  = r_stable;
        if ((r_stable != n_last) && (count_ext > limit_ext)) begin
            n_stable = n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b0;
            r_stable <= 1'b0;
            r_count  <= {COUNT_BITS{1'b1}};
        end else if (i_enable) begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_count  <= n_count;
        end
    end

    assign o_stable = n_stable;

endmodule

// ===== sv/dscs_mode_fsm.sv =====
module dscs_mode_fsm
    import dscs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_enable,
    input  logic      i_raw_cam,
    input  t_levels   i_levels,
    output t_decision o_decision
);

    t_mode r_mode;
    logic  r_started;
    t_mode cur_mode;
    t_mode n_mode;
    t_dir  dir;

    // The first word after reset takes its starting mode from the raw cam pin.
    always_comb begin
        if (r_started) begin
            cur_mode = r_mode;
        end else if (i_raw_cam) begin
            cur_mode = MODE_COCKED;
        end else begin
            cur_mode = MODE_IDLE;
        end
    end

    // Mode transitions; disarm wins where it applies.
    always_comb begin
        n_mode = cur_mode;
        case (cur_mode)
            MODE_IDLE: begin
                if (i_levels.dis) n_mode = MODE_RESETTING;
                else if (i_levels.arm) n_mode = MODE_COCKING;
            end
            MODE_COCKING: begin
                if (i_levels.dis) n_mode = MODE_RESETTING;
                else if (i_levels.cam) n_mode = MODE_COCKED;
            end
            MODE_COCKED: begin
                if (i_levels.dis) n_mode = MODE_DECOCKING;
                else if (i_levels.arm) n_mode = MODE_FIRING;
            end
            MODE_FIRING: begin
                if (i_levels.dis) n_mode = MODE_DECOCKING;
                else if (!i_levels.cam) n_mode = MODE_COCKING;
            end
            MODE_DECOCKING: begin
                if (!i_levels.cam) n_mode = MODE_RESETTING;
            end
            MODE_RESETTING: begin
                if (i_levels.cam) n_mode = MODE_IDLE_AFTER_RESET;
            end
            MODE_IDLE_AFTER_RESET: begin
                if (i_levels.arm) n_mode = MODE_RECOCKING;
            end
            MODE_RECOCKING: begin
                if (i_levels.dis) n_mode = MODE_IDLE_AFTER_RESET;
                else if (!i_levels.cam) n_mode = MODE_COCKING;
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    // Drive direction follows the new mode.
    always_comb begin
        case (n_mode)
            MODE_DECOCKING, MODE_RESETTING:            dir = DIR_REVERSE;
            MODE_COCKING, MODE_FIRING, MODE_RECOCKING: dir = DIR_FORWARD;
            default:                                   dir = DIR_NEUTRAL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_started <= 1'b0;
        end else if (i_enable) begin
            r_mode    <= n_mode;
            r_started <= 1'b1;
        end
    end

    assign o_decision.mode = n_mode;
    assign o_decision.dir  = dir;

endmodule

// ===== sv/debounced_servo_cocking_sequencer.sv =====
// A word accepted is registered into the output register, or into the skid entry while the
// output register holds a result not yet taken. One word per cycle while the skid is empty;
// three debounce lanes and the mode sequencer decide each tick combinationally.
// A two-entry output stage (output register plus skid) keeps input ready while one result waits.
// Reset (synchronous, active low) restores the register defaults, clears the lanes
// with saturated counts, sets mode idle and empties the output stage.
module debounced_servo_cocking_sequencer
    import dscs_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dscs_in_if.sink           i_in,
    dscs_out_if.source        o_out,
    dscs_cfg_if.sink          i_cfg
);

    logic [LIMIT_W-1:0] r_debounce_limit;
    logic [PULSE_W-1:0] r_pulse_reverse;
    logic [PULSE_W-1:0] r_pulse_forward;
    logic [PULSE_W-1:0] r_pulse_neutral;

    logic      in_fire;
    logic      out_fire;
    logic      cfg_fire;
    logic      in_ready;
    logic [NUM_PINS-1:0] raw_inv;
    logic [NUM_PINS-1:0] lane_level;
    t_levels   levels;
    t_decision decision;
    t_result   n_result;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    assign in_ready = !r_skid_valid;
    assign in_fire  = i_in.valid && in_ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign cfg_fire = i_cfg.valid;

    // Configuration registers; the port always takes a word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= RST_DEBOUNCE_LIMIT;
            r_pulse_reverse  <= RST_PULSE_REVERSE;
            r_pulse_forward  <= RST_PULSE_FORWARD;
            r_pulse_neutral  <= RST_PULSE_NEUTRAL;
        end else if (cfg_fire) begin
            case (i_cfg.index)
                CFG_DEBOUNCE_LIMIT: r_debounce_limit <= i_cfg.data[LIMIT_W-1:0];
                CFG_PULSE_REVERSE:  r_pulse_reverse  <= i_cfg.data[PULSE_W-1:0];
                CFG_PULSE_FORWARD:  r_pulse_forward  <= i_cfg.data[PULSE_W-1:0];
                CFG_PULSE_NEUTRAL:  r_pulse_neutral  <= i_cfg.data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // The pins are active low; each lane sees the inverted raw level.
    assign raw_inv[LANE_ARM] = !i_in.trigger_pin;
    assign raw_inv[LANE_DIS] = !i_in.disarm_pin;
    assign raw_inv[LANE_CAM] = !i_in.cam_pin;

    for (genvar g = 0; g < NUM_PINS; g++) begin : g_lane
        dscs_debounce #(
            .COUNT_BITS (COUNT_BITS)
        ) u_debounce (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_enable (in_fire),
            .i_level  (raw_inv[g]),
            .i_limit  (r_debounce_limit),
            .o_stable (lane_level[g])
        );
    end

    // Merge the lane levels for the sequencer.
    assign levels.arm = lane_level[LANE_ARM];
    assign levels.dis = lane_level[LANE_DIS];
    assign levels.cam = lane_level[LANE_CAM];

    dscs_mode_fsm u_mode_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (in_fire),
        .i_raw_cam  (i_in.cam_pin),
        .i_levels   (levels),
        .o_decision (decision)
    );

    // Build the result word from the decision and the pulse registers.
    always_comb begin
        case (decision.dir)
            DIR_REVERSE: n_result.servo_pulse = r_pulse_reverse;
            DIR_FORWARD: n_result.servo_pulse = r_pulse_forward;
            default:     n_result.servo_pulse = r_pulse_neutral;
        endcase
        n_result.led_on    = (decision.dir != DIR_NEUTRAL);
        n_result.mode_code = mode_to_code(decision.mode);
        n_result.drive_dir = decision.dir;
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

    assign i_in.ready        = in_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.servo_pulse = r_out.servo_pulse;
    assign o_out.led_on      = r_out.led_on;
    assign o_out.mode_code   = r_out.mode_code;
    assign o_out.drive_dir   = r_out.drive_dir;

endmodule

// ===== verif/dscs_sequence_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the sequencer, predicts every result word
// from the accepted pin words and compares the two field by field.
module dscs_sequence_checker
    import dscs_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dscs_in_if         i_in_bus,
    dscs_out_if        i_out_bus,
    dscs_cfg_if        i_cfg_bus,
    output int         o_errors,
    output int         o_pending,
    output int         o_results,
    output logic [7:0] o_modes_seen
);

    // Shadow copy of the configuration registers.
    logic [LIMIT_W-1:0] limit_q;
    logic [PULSE_W-1:0] reverse_q;
    logic [PULSE_W-1:0] forward_q;
    logic [PULSE_W-1:0] neutral_q;

    // Shadow copy of the debounce lanes and the sequencer.
    logic [NUM_PINS-1:0]   stable_q;
    logic [NUM_PINS-1:0]   last_q;
    logic [COUNT_BITS-1:0] quiet_q [NUM_PINS];
    logic [MODE_W-1:0]     mode_q;
    logic                  started_q;

    // Result words predicted but not yet seen on the output.
    t_result expected_words [$];

    // Advances the shadow state by one tick and returns the result word.
    function automatic t_result predict_tick(input logic [NUM_PINS-1:0] raw);
        logic              level;
        logic              arm;
        logic              dis;
        logic              cam;
        logic [MODE_W-1:0] nxt;
        t_dir              dir;
        t_result           word;
        int                k;

        // The very first tick takes its mode from the raw cam switch.
        if (!started_q) begin
            mode_q    = raw[LANE_CAM] ? CODE_COCKED : CODE_IDLE;
            started_q = 1'b1;
        end

        // Each lane inverts its pin and follows a level that held long enough.
        for (k = 0; k < NUM_PINS; k++) begin
            level = ~raw[k];
            if (level != last_q[k]) begin
                last_q[k]  = level;
                quiet_q[k] = '0;
            end else if (quiet_q[k] != '1) begin
                quiet_q[k] = quiet_q[k] + 1'b1;
            end
            if (stable_q[k] != last_q[k] && quiet_q[k] > limit_q) begin
                stable_q[k] = last_q[k];
            end
        end
        arm = stable_q[LANE_ARM];
        dis = stable_q[LANE_DIS];
        cam = stable_q[LANE_CAM];

        // Mode transition; disarm wins wherever it is listed.
        nxt = mode_q;
        case (mode_q)
            CODE_IDLE: begin
                if (dis) nxt = CODE_RESETTING;
                else if (arm) nxt = CODE_COCKING;
            end
            CODE_COCKING: begin
                if (dis) nxt = CODE_RESETTING;
                else if (cam) nxt = CODE_COCKED;
            end
            CODE_COCKED: begin
                if (dis) nxt = CODE_DECOCKING;
                else if (arm) nxt = CODE_FIRING;
            end
            CODE_FIRING: begin
                if (dis) nxt = CODE_DECOCKING;
                else if (!cam) nxt = CODE_COCKING;
            end
            CODE_DECOCKING: begin
                if (!cam) nxt = CODE_RESETTING;
            end
            CODE_RESETTING: begin
                if (cam) nxt = CODE_IDLE_AFTER_RESET;
            end
            CODE_IDLE_AFTER_RESET: begin
                if (arm) nxt = CODE_RECOCKING;
            end
            default: begin
                if (dis) nxt = CODE_IDLE_AFTER_RESET;
                else if (!cam) nxt = CODE_COCKING;
            end
        endcase
        mode_q = nxt;

        // The servo direction follows the new mode.
        case (nxt)
            CODE_DECOCKING, CODE_RESETTING:             dir = DIR_REVERSE;
            CODE_COCKING, CODE_FIRING, CODE_RECOCKING:  dir = DIR_FORWARD;
            default:                                    dir = DIR_NEUTRAL;
        endcase

        case (dir)
            DIR_REVERSE: word.servo_pulse = reverse_q;
            DIR_FORWARD: word.servo_pulse = forward_q;
            default:     word.servo_pulse = neutral_q;
        endcase
        word.led_on    = (dir != DIR_NEUTRAL);
        word.mode_code = nxt;
        word.drive_dir = dir;
        return word;
    endfunction

    // Per-edge bookkeeping: register writes, result checks, new predictions.
    always @(posedge i_clk) begin : monitor
        t_result             got;
        t_result             want;
        logic [NUM_PINS-1:0] raw;

        if (!i_rst_n) begin
            limit_q   = RST_DEBOUNCE_LIMIT;
            reverse_q = RST_PULSE_REVERSE;
            forward_q = RST_PULSE_FORWARD;
            neutral_q = RST_PULSE_NEUTRAL;
            stable_q  = '0;
            last_q    = '0;
            for (int k = 0; k < NUM_PINS; k++) quiet_q[k] = '1;
            mode_q    = CODE_IDLE;
            started_q = 1'b0;
            expected_words.delete();
            o_errors     = 0;
            o_pending    = 0;
            o_results    = 0;
            o_modes_seen = '0;
        end else begin
            // The bench must make register writes only while nothing is in flight; the checker does not enforce it.
            if (i_cfg_bus.valid && i_cfg_bus.ready) begin
                case (i_cfg_bus.index)
                    CFG_DEBOUNCE_LIMIT: limit_q   = i_cfg_bus.data[LIMIT_W-1:0];
                    CFG_PULSE_REVERSE:  reverse_q = i_cfg_bus.data[PULSE_W-1:0];
                    CFG_PULSE_FORWARD:  forward_q = i_cfg_bus.data[PULSE_W-1:0];
                    default:            neutral_q = i_cfg_bus.data[PULSE_W-1:0];
                endcase
            end

            // Compare an accepted result word with the oldest prediction.
            if (i_out_bus.valid && i_out_bus.ready) begin
                got.servo_pulse = i_out_bus.servo_pulse;
                got.led_on      = i_out_bus.led_on;
                got.mode_code   = i_out_bus.mode_code;
                got.drive_dir   = t_dir'(i_out_bus.drive_dir);
                o_results++;
                o_modes_seen[got.mode_code] = 1'b1;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, actual %h",
                             $time, got);
                    o_errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.servo_pulse !== want.servo_pulse) begin
                        $display("%0t: servo_pulse mismatch: expected %0d, actual %0d",
                                 $time, want.servo_pulse, got.servo_pulse);
                        o_errors++;
                    end
                    if (got.led_on !== want.led_on) begin
                        $display("%0t: led_on mismatch: expected %0b, actual %0b",
                                 $time, want.led_on, got.led_on);
                        o_errors++;
                    end
                    if (got.mode_code !== want.mode_code) begin
                        $display("%0t: mode_code mismatch: expected %0d, actual %0d",
                                 $time, want.mode_code, got.mode_code);
                        o_errors++;
                    end
                    if (got.drive_dir !== want.drive_dir) begin
                        $display("%0t: drive_dir mismatch: expected %0d, actual %0d",
                                 $time, want.drive_dir, got.drive_dir);
                        o_errors++;
                    end
                end
            end

            // Every accepted pin word causes exactly one result word.
            if (i_in_bus.valid && i_in_bus.ready) begin
                raw[LANE_ARM] = i_in_bus.trigger_pin;
                raw[LANE_DIS] = i_in_bus.disarm_pin;
                raw[LANE_CAM] = i_in_bus.cam_pin;
                expected_words.push_back(predict_tick(raw));
            end
            o_pending = expected_words.size();
        end
    end

endmodule

// ===== verif/debounced_servo_cocking_sequencer_tb.sv =====
`timescale 1ns / 1ps

module debounced_servo_cocking_sequencer_tb;
    import dscs_pkg::*;

    localparam int COUNT_BITS      = 16;
    localparam int STALL_LIMIT     = 2000;
    localparam int PRESSURE_CYCLES = 80;
    localparam int TAIL_CYCLES     = 8;
    localparam int PULSE_TOP       = 20000;
    localparam int PULSE_ALL_ONES  = 32767;

    // Directed walk through the modes, pins as {trigger, disarm, cam}.
    localparam int                WALK_LEN  = 12;
    localparam logic [3*12-1:0]   WALK_PINS = {
        3'b011, 3'b110, 3'b010, 3'b111, 3'b101, 3'b110,
        3'b010, 3'b100, 3'b010, 3'b111, 3'b110, 3'b100
    };

    logic i_clk;
    logic i_rst_n;

    dscs_in_if  in_bus ();
    dscs_out_if out_bus ();
    dscs_cfg_if cfg_bus ();

    int         tx_idle_pct;
    int         rx_idle_pct;
    logic       pressure_armed;
    int         errors;
    int         pending;
    int         results;
    logic [7:0] modes_seen;
    int         words_sent   = 0;
    int         cfg_writes   = 0;
    int         quiet_cycles = 0;

    debounced_servo_cocking_sequencer #(
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    dscs_sequence_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_bus     (in_bus),
        .i_out_bus    (out_bus),
        .i_cfg_bus    (cfg_bus),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_modes_seen (modes_seen)
    );

    // Free-running clock, 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result receiver: random back-pressure plus one long hold-off on request.
    initial begin : receiver
        int   stall_left;
        logic pressure_done;

        stall_left    = 0;
        pressure_done = 1'b0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_armed && !pressure_done) begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, giving up", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one pin word, with random idle cycles first; entered at a falling edge.
    task automatic send_word(input logic [2:0] pins);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.trigger_pin <= pins[2];
        in_bus.disarm_pin  <= pins[1];
        in_bus.cam_pin     <= pins[0];
        do @(posedge i_clk); while (!in_bus.ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Writes one register; the caller lowers valid after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // Stops offering words and waits until every result word has come back.
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Loads a full register setting while the block is idle.
    task automatic program_all(input int limit, input int rev, input int fwd, input int neu);
        drain();
        write_reg(CFG_DEBOUNCE_LIMIT, limit[CFG_DAT_W-1:0]);
        write_reg(CFG_PULSE_REVERSE, {1'b0, rev[PULSE_W-1:0]});
        write_reg(CFG_PULSE_FORWARD, {1'b0, fwd[PULSE_W-1:0]});
        write_reg(CFG_PULSE_NEUTRAL, {1'b0, neu[PULSE_W-1:0]});
        cfg_bus.valid <= 1'b0;
    endtask

    // Button-like stimulus: pin levels held for random stretches, with the
    // odd one-tick glitch and short bursts of noise.
    task automatic run_random(input int n_words, input int max_hold);
        int         left;
        int         hold;
        int         i;
        logic [2:0] pins;
        logic [2:0] glitch;

        left = n_words;
        while (left > 0) begin
            pins[2] = $urandom_range(1);
            pins[1] = ($urandom_range(99) < 75);
            pins[0] = $urandom_range(1);
            if ($urandom_range(9) == 0) hold = 1;
            else hold = $urandom_range(max_hold, 1);
            for (i = 0; i < hold && left > 0; i++) begin
                glitch = ($urandom_range(19) == 0) ? (3'b001 << $urandom_range(2)) : 3'b000;
                send_word(pins ^ glitch);
                left--;
            end
        end
    endtask

    // Main sequence: reset, directed walk, then several register settings.
    initial begin
        in_bus.valid       = 1'b0;
        in_bus.trigger_pin = 1'b1;
        in_bus.disarm_pin  = 1'b1;
        in_bus.cam_pin     = 1'b1;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_DEBOUNCE_LIMIT;
        cfg_bus.data       = '0;
        tx_idle_pct        = 30;
        rx_idle_pct        = 52;
        pressure_armed     = 1'b0;
        i_rst_n            = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First word with the cam switch low starts the sequencer idle.
        send_word(3'b110);

        // With a zero limit each level follows after two ticks.
        drain();
        write_reg(CFG_DEBOUNCE_LIMIT, '0);
        cfg_bus.valid <= 1'b0;
        for (int i = WALK_LEN - 1; i >= 0; i--) begin
            send_word(WALK_PINS[3*i +: 3]);
            send_word(WALK_PINS[3*i +: 3]);
        end

        // Short debounce, random pulse widths.
        program_all($urandom_range(3), $urandom_range(PULSE_TOP), $urandom_range(PULSE_TOP),
                    $urandom_range(PULSE_TOP));
        run_random(450, 10);

        // Limit of 65534: no level follows within these words; pulse extremes, one above range.
        program_all(65534, 0, PULSE_TOP, PULSE_ALL_ONES);
        run_random(40, 20);

        // Sender now stalls more than the receiver.
        tx_idle_pct = 52;
        rx_idle_pct = 30;
        program_all($urandom_range(7), $urandom_range(PULSE_TOP), $urandom_range(PULSE_TOP),
                    $urandom_range(PULSE_TOP));
        run_random(450, 20);

        program_all(1, PULSE_TOP, 0, PULSE_TOP);
        run_random(200, 6);

        // Full rate on both sides; the receiver holds off once to fill the block.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_all(30, $urandom_range(PULSE_TOP), $urandom_range(PULSE_TOP),
                    $urandom_range(PULSE_TOP));
        pressure_armed = 1'b1;
        run_random(400, 80);

        program_all(2, $urandom_range(PULSE_ALL_ONES), $urandom_range(PULSE_ALL_ONES),
                    $urandom_range(PULSE_ALL_ONES));
        run_random(200, 8);

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d pin words under eight register settings (%0d register writes).",
                 words_sent, cfg_writes);
        $display("Checked %0d result words; modes reached, by code: %b", results, modes_seen);
        if (pending != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending);
        end
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
